// File: sv/slpc_pkg.sv
`timescale 1ns / 1ps
// Package for the status LED pattern controller: word layouts, pattern codes,
// register indexes and reset values. No dependencies.
package slpc_pkg;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 8;
   localparam int CSR_ADDR_W  = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int TIME_W      = 32;

   // Register indexes of the control port.
   localparam logic [CSR_ADDR_W-1:0] CSR_GREEN_FLASH   = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RED_STORAGE   = 8'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RED_BUS       = 8'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RED_BATT_LOW  = 8'd3;

   // Period reset values in milliseconds.
   localparam logic [CSR_DATA_W-1:0] GREEN_FLASH_RESET  = 16'd1000;
   localparam logic [CSR_DATA_W-1:0] RED_STORAGE_RESET  = 16'd500;
   localparam logic [CSR_DATA_W-1:0] RED_BUS_RESET      = 16'd250;
   localparam logic [CSR_DATA_W-1:0] RED_BATT_LOW_RESET = 16'd167;

   // Battery level codes.
   localparam logic [1:0] BATT_LOW      = 2'd1;
   localparam logic [1:0] BATT_CRITICAL = 2'd2;

   typedef enum logic [1:0] {
      GRN_OFF    = 2'd0,
      GRN_STEADY = 2'd1,
      GRN_FLASH  = 2'd2
   } green_mode_type;

   typedef enum logic [2:0] {
      RED_OFF      = 3'd0,
      RED_STEADY   = 3'd1,
      RED_STORAGE  = 3'd2,
      RED_BUS      = 3'd3,
      RED_BATT_LOW = 3'd4
   } red_mode_type;

   // Request word, last field in the lowest bits.
   typedef struct packed {
      logic [1:0]        pad;
      logic              bus_fault_report;
      logic              ack_faults;
      logic [1:0]        battery_level;
      logic              position_fix;
      logic              storage_mounted;
      logic [TIME_W-1:0] write_error_count;
      logic [TIME_W-1:0] now_ms;
   } req_word_type;

   // Response word, last field in the lowest bits.
   typedef struct packed {
      logic         pad;
      red_mode_type red_mode;
      green_mode_type green_mode;
      logic         red_pin;
      logic         green_pin;
   } rsp_word_type;

   // Timer of one blinking LED.
   typedef struct packed {
      logic [TIME_W-1:0] stamp;
      logic              lit;
   } blink_type;

   // Toggle once the wrapping signed time since the last toggle reaches the period.
   function automatic blink_type blink_step(blink_type cur, logic [CSR_DATA_W-1:0] period,
                                            logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] diff;
      blink_type         nxt;
      diff = now - cur.stamp;
      nxt  = cur;
      if (!diff[TIME_W-1] && (diff >= {{(TIME_W-CSR_DATA_W){1'b0}}, period})) begin
         nxt.stamp = now;
         nxt.lit   = ~cur.lit;
      end
      return nxt;
   endfunction

endpackage

// File: sv/status_led_pattern_controller.sv
`timescale 1ns / 1ps
// Status LED pattern controller top level: input register, evaluation logic,
// fault latches, LED timers and result register. Depends on slpc_pkg.
//
// Usage: each word on the req_ channel is one evaluation at time now_ms. It
// updates the two fault latches (acknowledge clears both, then the bus report
// and a rise of the write-error count set them), picks the green and red
// patterns and returns exactly one word on the rsp_ channel with both pin
// levels and both pattern codes. Blink timers run on the timestamps carried
// in the words, not on the clock.
// The accepted word is held in the input register while the evaluation logic
// feeds the result register, which drives rsp_tvalid.
// Throughput is one word per cycle while the receiver does not stall; the loop
// that sets it is the state update (latches, patterns, timers).
// When the receiver stalls, the result register holds its word and the input
// register takes one more word; req_tready then drops until rsp_tready returns.
// The csr_ channel writes the four blink periods and is always ready. The user
// must write it only while the block is idle, which the block does not enforce.
// Indexes above three are ignored. Reset (synchronous, active high) empties both
// registers, clears the latches, turns both patterns off, restores default periods.
module status_led_pattern_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata, from bit 0: now_ms[32], write_error_count[32], storage_mounted,
   // position_fix, battery_level[2], ack_faults, bus_fault_report, zero pad[2].
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [slpc_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // rsp_tdata, from bit 0: green pin level, red pin level, green_mode[2],
   // red_mode[3], zero pad[1].
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [slpc_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [slpc_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [slpc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import slpc_pkg::*;

   // Input register.
   logic          in_valid_ff, in_valid_in;
   req_word_type  in_word_ff, in_word_in;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_word_ff, rsp_word_in;

   // Period registers.
   logic [CSR_DATA_W-1:0] green_period_ff, green_period_in;
   logic [CSR_DATA_W-1:0] storage_period_ff, storage_period_in;
   logic [CSR_DATA_W-1:0] bus_period_ff, bus_period_in;
   logic [CSR_DATA_W-1:0] batt_period_ff, batt_period_in;

   // Evaluation state.
   logic [TIME_W-1:0] last_errors_ff, last_errors_in;
   logic              storage_fault_ff, storage_fault_in;
   logic              bus_fault_ff, bus_fault_in;
   green_mode_type    green_mode_ff, green_mode_in;
   red_mode_type      red_mode_ff, red_mode_in;
   blink_type         green_timer_ff, green_timer_in;
   blink_type         red_timer_ff, red_timer_in;

   logic              advance;
   logic              evaluate;
   logic              csr_write;
   blink_type         green_start, red_start;
   logic [CSR_DATA_W-1:0] red_period;
   logic              green_pin, red_pin;

   // The evaluation stage moves whenever the result register is empty or
   // being drained this cycle.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign evaluate   = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;

   // Input register next value.
   always_comb begin
      in_word_in  = in_word_ff;
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_word_in  = req_word_type'(req_tdata);
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Control register writes.
   always_comb begin
      green_period_in   = green_period_ff;
      storage_period_in = storage_period_ff;
      bus_period_in     = bus_period_ff;
      batt_period_in    = batt_period_ff;
      if (csr_write) begin
         unique case (csr_addr)
            CSR_GREEN_FLASH:  green_period_in   = csr_wdata;
            CSR_RED_STORAGE:  storage_period_in = csr_wdata;
            CSR_RED_BUS:      bus_period_in     = csr_wdata;
            CSR_RED_BATT_LOW: batt_period_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   // Evaluation of one word.
   always_comb begin
      last_errors_in   = last_errors_ff;
      storage_fault_in = storage_fault_ff;
      bus_fault_in     = bus_fault_ff;
      green_mode_in    = green_mode_ff;
      red_mode_in      = red_mode_ff;
      green_timer_in   = green_timer_ff;
      red_timer_in     = red_timer_ff;
      green_start      = green_timer_ff;
      red_start        = red_timer_ff;
      red_period       = batt_period_ff;
      green_pin        = 1'b0;
      red_pin          = 1'b0;

      // Latches: acknowledge first, then the bus report, then the error count.
      if (in_word_ff.ack_faults) begin
         storage_fault_in = 1'b0;
         bus_fault_in     = 1'b0;
      end
      if (in_word_ff.bus_fault_report) begin
         bus_fault_in = 1'b1;
      end
      if (in_word_ff.write_error_count > last_errors_ff) begin
         storage_fault_in = 1'b1;
      end
      last_errors_in = in_word_ff.write_error_count;

      // Green pattern.
      if (!in_word_ff.storage_mounted) begin
         green_mode_in = GRN_OFF;
      end else if (in_word_ff.position_fix) begin
         green_mode_in = GRN_STEADY;
      end else begin
         green_mode_in = GRN_FLASH;
      end
      // A new pattern restarts unlit with its timer at the current time.
      if (green_mode_in != green_mode_ff) begin
         green_start.stamp = in_word_ff.now_ms;
         green_start.lit   = 1'b0;
      end
      green_timer_in = green_start;
      case (green_mode_in)
         GRN_STEADY: green_pin = 1'b1;
         GRN_FLASH: begin
            green_timer_in = blink_step(green_start, green_period_ff, in_word_ff.now_ms);
            green_pin      = green_timer_in.lit;
         end
         default:    green_pin = 1'b0;
      endcase

      // Red pattern, first match wins.
      if (in_word_ff.battery_level == BATT_CRITICAL) begin
         red_mode_in = RED_STEADY;
      end else if (storage_fault_in) begin
         red_mode_in = RED_STORAGE;
      end else if (bus_fault_in) begin
         red_mode_in = RED_BUS;
      end else if (in_word_ff.battery_level == BATT_LOW) begin
         red_mode_in = RED_BATT_LOW;
      end else begin
         red_mode_in = RED_OFF;
      end
      if (red_mode_in != red_mode_ff) begin
         red_start.stamp = in_word_ff.now_ms;
         red_start.lit   = 1'b0;
      end
      case (red_mode_in)
         RED_STORAGE: red_period = storage_period_ff;
         RED_BUS:     red_period = bus_period_ff;
         default:     red_period = batt_period_ff;
      endcase
      red_timer_in = red_start;
      case (red_mode_in) inside
         RED_STEADY: red_pin = 1'b1;
         RED_STORAGE, RED_BUS, RED_BATT_LOW: begin
            red_timer_in = blink_step(red_start, red_period, in_word_ff.now_ms);
            red_pin      = red_timer_in.lit;
         end
         default:    red_pin = 1'b0;
      endcase
   end

   // Result register next value.
   always_comb begin
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff;
      if (evaluate) begin
         rsp_word_in.pad        = 1'b0;
         rsp_word_in.red_mode   = red_mode_in;
         rsp_word_in.green_mode = green_mode_in;
         rsp_word_in.red_pin    = red_pin;
         rsp_word_in.green_pin  = green_pin;
         rsp_valid_in           = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      rsp_word_ff <= rsp_word_in;
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         green_period_ff   <= GREEN_FLASH_RESET;
         storage_period_ff <= RED_STORAGE_RESET;
         bus_period_ff     <= RED_BUS_RESET;
         batt_period_ff    <= RED_BATT_LOW_RESET;
         last_errors_ff    <= '0;
         storage_fault_ff  <= 1'b0;
         bus_fault_ff      <= 1'b0;
         green_mode_ff     <= GRN_OFF;
         red_mode_ff       <= RED_OFF;
         green_timer_ff    <= '0;
         red_timer_ff      <= '0;
      end else begin
         in_valid_ff       <= in_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         green_period_ff   <= green_period_in;
         storage_period_ff <= storage_period_in;
         bus_period_ff     <= bus_period_in;
         batt_period_ff    <= batt_period_in;
         if (evaluate) begin
            last_errors_ff   <= last_errors_in;
            storage_fault_ff <= storage_fault_in;
            bus_fault_ff     <= bus_fault_in;
            green_mode_ff    <= green_mode_in;
            red_mode_ff      <= red_mode_in;
            green_timer_ff   <= green_timer_in;
            red_timer_ff     <= red_timer_in;
         end
      end
   end

   // An evaluated word always lands in the result register.
   assert property (@(posedge clock) disable iff (reset) evaluate |=> rsp_valid_ff)
      else $error("evaluated word did not reach the result register");

   // A bus report in an evaluated word leaves the bus latch set.
   assert property (@(posedge clock) disable iff (reset)
      (evaluate && in_word_ff.bus_fault_report) |=> bus_fault_ff)
      else $error("bus fault latch not set after report");

   // The red solid pattern drives its pin high and the green off pattern drives it low.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.red_mode == RED_STEADY) |-> rsp_word_ff.red_pin)
      else $error("red solid pattern with pin low");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.green_mode == GRN_OFF) |-> !rsp_word_ff.green_pin)
      else $error("green off pattern with pin high");

   // The reported pattern matches the stored pattern for the last evaluation.
   assert property (@(posedge clock) disable iff (reset)
      evaluate |=> (rsp_word_ff.red_mode == red_mode_ff &&
                    rsp_word_ff.green_mode == green_mode_ff))
      else $error("reported pattern differs from stored pattern");

endmodule
